[design/linear_adsr_envelope_top_defines.svh]
// Assertion macros shared by the checker of the envelope block.
// Both expect signals named clk and arst_n in the scope where they are used.
`ifndef LINEAR_ADSR_ENVELOPE_TOP_DEFINES_SVH
`define LINEAR_ADSR_ENVELOPE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LAE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LAE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/lae_pkg.sv]
`default_nettype none

package lae_pkg;

	localparam int CFG_BITS       = 32;
	localparam int SUS_BITS       = 16;
	localparam int OP_BITS        = 2;
	localparam int CFG_INDEX_BITS = 2;
	localparam int PHASE_BITS     = 3;

	localparam logic [OP_BITS-1:0] OP_START   = 2'd1;
	localparam logic [OP_BITS-1:0] OP_RELEASE = 2'd2;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_ATTACK  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_DECAY   = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_RELEASE = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SUSTAIN = 2'd3;

	localparam logic [CFG_BITS-1:0] ATTACK_RST  = 32'd4800;
	localparam logic [CFG_BITS-1:0] DECAY_RST   = 32'd9600;
	localparam logic [CFG_BITS-1:0] RELEASE_RST = 32'd24000;
	localparam logic [SUS_BITS-1:0] SUSTAIN_RST = 16'd49152;

	typedef enum logic [PHASE_BITS-1:0] {
		PH_IDLE    = 3'd0,
		PH_ATTACK  = 3'd1,
		PH_DECAY   = 3'd2,
		PH_SUSTAIN = 3'd3,
		PH_RELEASE = 3'd4
	} phase_t;

	typedef struct packed {
		logic accept;
		logic diff;
		logic eval;
		logic finish;
	} lae_cmd_t;

	typedef struct packed {
		logic div_done;
	} lae_sts_t;

endpackage

`default_nettype wire

[design/lae_div.sv]
`default_nettype none

// Computes floor(num * full / den) for num < den, one bit of full per cycle,
// most significant bit first.
module lae_div
	import lae_pkg::*;
#(
	parameter int LEVEL_BITS = 16
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [CFG_BITS-1:0]   num,
	input  logic [CFG_BITS-1:0]   den,
	input  logic [LEVEL_BITS-1:0] full,
	output logic [LEVEL_BITS-1:0] quo,
	output logic                  done
);

	localparam int CNT_BITS = $clog2(LEVEL_BITS + 1);
	localparam int RW       = CFG_BITS + 2;

	logic [CNT_BITS-1:0]   cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [CFG_BITS-1:0]   num_q;
	logic [CFG_BITS-1:0]   den_q;
	logic [CFG_BITS-1:0]   rem_q;
	logic [LEVEL_BITS-1:0] full_q;
	logic [LEVEL_BITS-1:0] quo_q;

	logic [RW-1:0] acc;
	logic [RW-1:0] den1;
	logic [RW-1:0] den2;
	logic [RW-1:0] rem_w;
	logic [1:0]    digit;

	// The partial remainder stays below den, so after doubling and adding
	// num it is below three times den: the step digit is 0, 1 or 2.
	always_comb begin
		den1 = RW'(den_q);
		den2 = {1'b0, den_q, 1'b0};
		acc  = {1'b0, rem_q, 1'b0} + (full_q[LEVEL_BITS-1] ? RW'(num_q) : '0);
		priority if (acc >= den2) begin
			digit = 2'd2;
			rem_w = acc - den2;
		end else if (acc >= den1) begin
			digit = 2'd1;
			rem_w = acc - den1;
		end else begin
			digit = 2'd0;
			rem_w = acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_BITS'(LEVEL_BITS);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_BITS'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			full_q <= full;
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= rem_w[CFG_BITS-1:0];
			full_q <= full_q << 1;
			quo_q  <= LEVEL_BITS'({quo_q, 1'b0} + (LEVEL_BITS + 1)'(digit));
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

`default_nettype wire

[design/lae_dp.sv]
`default_nettype none

module lae_dp
	import lae_pkg::*;
#(
	parameter int TIME_BITS  = 32,
	parameter int LEVEL_BITS = 16
)
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]       cfg_data,
	input  lae_cmd_t                  cmd,
	output lae_sts_t                  sts,
	input  logic [OP_BITS-1:0]        op,
	input  logic [TIME_BITS-1:0]      timestamp,
	output logic [LEVEL_BITS-1:0]     level,
	output logic [PHASE_BITS-1:0]     phase
);

	localparam int CW   = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;
	localparam int SUMW = CW + 1;
	localparam int LSW  = (LEVEL_BITS > SUS_BITS) ? LEVEL_BITS : SUS_BITS;
	localparam logic [LEVEL_BITS-1:0] FULL = {LEVEL_BITS{1'b1}};

	typedef enum logic [1:0] {
		LV_BASE,
		LV_SUB,
		LV_QUO
	} lvl_mode_t;

	// Configuration.
	logic [CFG_BITS-1:0] attack_q;
	logic [CFG_BITS-1:0] decay_q;
	logic [CFG_BITS-1:0] release_q;
	logic [SUS_BITS-1:0] sustain_q;

	// Envelope state.
	phase_t                phase_q;
	logic [TIME_BITS-1:0]  note_start_q;
	logic [TIME_BITS-1:0]  rel_start_q;
	logic [LEVEL_BITS-1:0] rel_level_q;

	// Working registers of the current word.
	logic                  rel_pend_q;
	logic [TIME_BITS-1:0]  ts_q;
	logic [TIME_BITS-1:0]  e_q;
	logic [TIME_BITS-1:0]  r_q;
	logic [CFG_BITS:0]     ad_sum_q;
	lvl_mode_t             mode_q;
	logic [LEVEL_BITS-1:0] base_q;
	logic [LEVEL_BITS-1:0] out_level_q;
	phase_t                out_phase_q;

	logic [LEVEL_BITS-1:0] s_sat;
	logic [SUMW-1:0]       e_x;
	logic [SUMW-1:0]       atk_x;
	logic [SUMW-1:0]       d_x;
	logic                  e_lt_atk;
	logic                  e_lt_ad;
	logic                  r_lt_rel;
	phase_t                cand;
	phase_t                np;
	lvl_mode_t             mode;
	logic [LEVEL_BITS-1:0] base;
	logic [CFG_BITS-1:0]   div_num;
	logic [CFG_BITS-1:0]   div_den;
	logic [LEVEL_BITS-1:0] div_full;
	logic [LEVEL_BITS-1:0] quo;
	logic                  div_done;
	logic [LEVEL_BITS-1:0] lvl_now;

	always_comb begin
		if (LSW'(sustain_q) > LSW'(FULL)) begin
			s_sat = FULL;
		end else begin
			s_sat = LEVEL_BITS'(sustain_q);
		end
	end

	// Position of the note relative to the attack and decay boundaries.
	assign e_x      = SUMW'(e_q);
	assign atk_x    = SUMW'(attack_q);
	assign d_x      = e_x - atk_x;
	assign e_lt_atk = e_x < atk_x;
	assign e_lt_ad  = e_x < SUMW'(ad_sum_q);
	assign r_lt_rel = SUMW'(r_q) < SUMW'(release_q);

	always_comb begin
		if (e_lt_atk) begin
			cand = PH_ATTACK;
		end else if (e_lt_ad) begin
			cand = PH_DECAY;
		end else begin
			cand = PH_SUSTAIN;
		end
	end

	// The phase never steps back while the note is held, even when the
	// timestamp does.
	always_comb begin
		np       = PH_IDLE;
		mode     = LV_BASE;
		base     = '0;
		div_num  = '0;
		div_den  = attack_q;
		div_full = '0;
		unique case (phase_q)
			PH_ATTACK, PH_DECAY, PH_SUSTAIN: begin
				np = (cand > phase_q) ? cand : phase_q;
				priority if (np == PH_ATTACK) begin
					mode     = LV_QUO;
					div_num  = CFG_BITS'(e_q);
					div_den  = attack_q;
					div_full = FULL;
				end else if (np == PH_DECAY) begin
					if (cand == PH_ATTACK && decay_q == '0) begin
						base = s_sat;
					end else begin
						mode     = LV_SUB;
						base     = FULL;
						div_num  = (cand == PH_ATTACK) ? '0 : CFG_BITS'(d_x);
						div_den  = decay_q;
						div_full = FULL - s_sat;
					end
				end else begin
					base = s_sat;
				end
			end
			PH_RELEASE: begin
				if (r_lt_rel) begin
					np       = PH_RELEASE;
					mode     = LV_SUB;
					base     = rel_level_q;
					div_num  = CFG_BITS'(r_q);
					div_den  = release_q;
					div_full = rel_level_q;
				end
			end
			default: begin
				np = PH_IDLE;
			end
		endcase
	end

	lae_div #(
		.LEVEL_BITS(LEVEL_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.eval),
		.num   (div_num),
		.den   (div_den),
		.full  (div_full),
		.quo   (quo),
		.done  (div_done)
	);

	always_comb begin
		unique case (mode_q)
			LV_QUO:  lvl_now = quo;
			LV_SUB:  lvl_now = base_q - quo;
			LV_BASE: lvl_now = base_q;
			default: lvl_now = base_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= ATTACK_RST;
			decay_q   <= DECAY_RST;
			release_q <= RELEASE_RST;
			sustain_q <= SUSTAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ATTACK:  attack_q  <= cfg_data;
				CFG_DECAY:   decay_q   <= cfg_data;
				CFG_RELEASE: release_q <= cfg_data;
				CFG_SUSTAIN: sustain_q <= cfg_data[SUS_BITS-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			note_start_q <= '0;
			rel_start_q  <= '0;
			rel_level_q  <= '0;
			rel_pend_q   <= 1'b0;
		end else begin
			priority if (cmd.accept) begin
				rel_pend_q <= (op == OP_RELEASE) && (phase_q != PH_IDLE);
				if (op == OP_START) begin
					note_start_q <= timestamp;
					phase_q      <= PH_ATTACK;
				end
			end else if (cmd.eval) begin
				phase_q <= np;
			end else if (cmd.finish) begin
				// A release latches the level just reached and restarts
				// its ramp from there.
				if (rel_pend_q && phase_q != PH_IDLE) begin
					rel_level_q <= lvl_now;
					rel_start_q <= ts_q;
					phase_q     <= (release_q == '0) ? PH_IDLE : PH_RELEASE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ts_q <= timestamp;
		end
		if (cmd.diff) begin
			e_q      <= ts_q - note_start_q;
			r_q      <= ts_q - rel_start_q;
			ad_sum_q <= (CFG_BITS + 1)'(attack_q) + (CFG_BITS + 1)'(decay_q);
		end
		if (cmd.eval) begin
			mode_q <= mode;
			base_q <= base;
		end
		if (cmd.finish) begin
			if (rel_pend_q && phase_q != PH_IDLE) begin
				if (release_q == '0) begin
					out_level_q <= '0;
					out_phase_q <= PH_IDLE;
				end else begin
					out_level_q <= lvl_now;
					out_phase_q <= PH_RELEASE;
				end
			end else begin
				out_level_q <= lvl_now;
				out_phase_q <= phase_q;
			end
		end
	end

	assign sts.div_done = div_done;
	assign level        = out_level_q;
	assign phase        = out_phase_q;

endmodule

`default_nettype wire

[design/lae_ctrl.sv]
`default_nettype none

module lae_ctrl
	import lae_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	output lae_cmd_t cmd,
	input  lae_sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_EVAL,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   m_valid_q;
	logic   slot_free;

	// The output register may be refilled in the cycle its word is taken.
	assign slot_free = !m_valid_q || m_tready;

	assign cmd.accept = ready_q && s_tvalid;
	assign cmd.diff   = (state_q == ST_DIFF);
	assign cmd.eval   = (state_q == ST_EVAL);
	assign cmd.finish = (state_q == ST_DONE) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ready_q   <= 1'b1;
			m_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.accept) begin
						state_q <= ST_DIFF;
						ready_q <= 1'b0;
					end
				end
				ST_DIFF: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (sts.div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign s_tready = ready_q;
	assign m_tvalid = m_valid_q;

endmodule

`default_nettype wire

[design/linear_adsr_envelope_top.sv]
// Each input word is taken in idle, then passes the difference, evaluate, divide and done steps;
// the done step waits until the output register is free, then fills it. One word is worked on at a time.
// The ramp divider retires one level bit per cycle during the divide step.
// The input side reopens while a finished word still waits in the output register.
// Reset (arst_n low, asynchronous): phase idle, start times and release level zero,
// lengths and sustain level back to their defaults, no result pending.
`default_nettype none

module linear_adsr_envelope_top
	import lae_pkg::*;
#(
	parameter int TIME_BITS  = 32,
	parameter int LEVEL_BITS = 16
)
(
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// op [1:0], timestamp [TIME_BITS+1:2], zero padding above
	input  logic [((OP_BITS+TIME_BITS+7)/8)*8-1:0]    s_tdata,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// level [LEVEL_BITS-1:0], phase [LEVEL_BITS+2:LEVEL_BITS], zero padding above
	output logic [((LEVEL_BITS+PHASE_BITS+7)/8)*8-1:0] m_tdata,
	input  logic                                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0]                 cfg_index,
	input  logic [CFG_BITS-1:0]                       cfg_data
);

	localparam int M_W = ((LEVEL_BITS + PHASE_BITS + 7) / 8) * 8;

	lae_cmd_t              cmd;
	lae_sts_t              sts;
	logic [LEVEL_BITS-1:0] level;
	logic [PHASE_BITS-1:0] phase;

	lae_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd),
		.sts     (sts)
	);

	lae_dp #(
		.TIME_BITS (TIME_BITS),
		.LEVEL_BITS(LEVEL_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.op       (s_tdata[OP_BITS-1:0]),
		.timestamp(s_tdata[OP_BITS+TIME_BITS-1:OP_BITS]),
		.level    (level),
		.phase    (phase)
	);

	assign m_tdata = M_W'({phase, level});

endmodule

`default_nettype wire

[design/lae_chk.sv]
`default_nettype none

`include "linear_adsr_envelope_top_defines.svh"

module lae_chk
	import lae_pkg::*;
#(
	parameter int LEVEL_BITS = 16
)
(
	input wire logic                                       clk,
	input wire logic                                       arst_n,
	input wire logic                                       s_tvalid,
	input wire logic                                       s_tready,
	input wire logic                                       m_tvalid,
	input wire logic                                       m_tready,
	input wire logic [((LEVEL_BITS+PHASE_BITS+7)/8)*8-1:0] m_tdata
);

	// A stalled result word must wait unchanged.
	`LAE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

	// Idle always reports a zero level.
	`LAE_ASSERT_NOW(a_idle_zero, m_tvalid && (m_tdata[LEVEL_BITS+2:LEVEL_BITS] == PH_IDLE), m_tdata[LEVEL_BITS-1:0] == '0, "idle word with nonzero level")

	// One word is worked on at a time.
	`LAE_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "input taken while a word is in work")

	// A fresh result comes only as the engine finishes and reopens its input.
	`LAE_ASSERT_NOW(a_rise_ready, $rose(m_tvalid), s_tready, "result shown while engine still busy")

endmodule

bind linear_adsr_envelope_top lae_chk #(
	.LEVEL_BITS(LEVEL_BITS)
) u_lae_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

`default_nettype wire

[tb/tb_linear_adsr_envelope_top.sv]
module tb_linear_adsr_envelope_top;
	import lae_pkg::*;

	localparam logic [OP_BITS-1:0] OP_UPDATE = 2'd0;
	// The unused op code behaves as a plain time update.
	localparam logic [OP_BITS-1:0] OP_SPARE  = 2'd3;

	localparam int RESET_CYCLES = 11;
	localparam int DRAIN_CYCLES = 50;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int REPORT_LIMIT = 10;
	localparam int IDLE_PERCENT = 26;

	// Matches m_tdata[18:0]: level in the low bits, phase above it.
	typedef struct packed {
		phase_t      phase;
		logic [15:0] level;
	} env_word_t;

	class envelope_scoreboard;
		localparam logic [15:0] FULL = 16'hFFFF;

		logic [31:0] attack_len;
		logic [31:0] decay_len;
		logic [31:0] release_len;
		logic [15:0] sustain_lvl;
		phase_t      phase;
		logic [31:0] note_t0;
		logic [31:0] release_t0;
		logic [15:0] release_lvl;
		env_word_t   expected_words[$];
		int          mismatches;
		int          words_checked;

		function new();
			attack_len    = ATTACK_RST;
			decay_len     = DECAY_RST;
			release_len   = RELEASE_RST;
			sustain_lvl   = SUSTAIN_RST;
			phase         = PH_IDLE;
			note_t0       = '0;
			release_t0    = '0;
			release_lvl   = '0;
			mismatches    = 0;
			words_checked = 0;
		endfunction

		function void set_lengths(logic [31:0] a, logic [31:0] d, logic [31:0] r,
				logic [15:0] s);
			attack_len  = a;
			decay_len   = d;
			release_len = r;
			sustain_lvl = s;
		endfunction

		// Exact floor(num * full / den); callers guarantee num < den.
		function logic [15:0] ramp(logic [31:0] num, logic [31:0] den, logic [15:0] full);
			logic [63:0] prod;
			prod = {32'b0, num} * {48'b0, full};
			return 16'(prod / {32'b0, den});
		endfunction

		// Advances the phase to time ts and returns the level there.
		function logic [15:0] level_at(logic [31:0] ts);
			logic [31:0] e;
			logic [31:0] d;
			logic [31:0] r;
			phase_t      cand;
			if (phase == PH_ATTACK || phase == PH_DECAY || phase == PH_SUSTAIN) begin
				e = ts - note_t0;
				d = '0;
				if (e < attack_len) begin
					cand = PH_ATTACK;
				end else begin
					d = e - attack_len;
					cand = (d < decay_len) ? PH_DECAY : PH_SUSTAIN;
				end
				// The phase never steps back when time runs backward.
				if (cand > phase)
					phase = cand;
				if (phase == PH_ATTACK)
					return ramp(e, attack_len, FULL);
				if (phase == PH_DECAY) begin
					if (cand == PH_ATTACK)
						d = '0;
					if (d >= decay_len)
						return sustain_lvl;
					return FULL - ramp(d, decay_len, FULL - sustain_lvl);
				end
				return sustain_lvl;
			end
			if (phase == PH_RELEASE) begin
				r = ts - release_t0;
				if (r >= release_len) begin
					phase = PH_IDLE;
					return '0;
				end
				return release_lvl - ramp(r, release_len, release_lvl);
			end
			phase = PH_IDLE;
			return '0;
		endfunction

		function void note_input(logic [1:0] op, logic [31:0] ts);
			logic [15:0] now;
			env_word_t   w;
			if (op == OP_START) begin
				note_t0 = ts;
				phase = PH_ATTACK;
			end else if (op == OP_RELEASE && phase != PH_IDLE) begin
				now = level_at(ts);
				if (phase != PH_IDLE) begin
					release_lvl = now;
					release_t0  = ts;
					phase       = PH_RELEASE;
				end
			end
			w.level = level_at(ts);
			w.phase = phase;
			expected_words.push_back(w);
		endfunction

		function void check_word(env_word_t got);
			env_word_t want;
			words_checked++;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("word %0d: unexpected, level %0d phase %0d",
						words_checked, got.level, got.phase);
				return;
			end
			want = expected_words.pop_front();
			if (got.level !== want.level || got.phase !== want.phase) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("word %0d: level exp %0d got %0d, phase exp %0d got %0d",
						words_checked, want.level, got.level, want.phase, got.phase);
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	// op [1:0], timestamp [33:2], zero padding above
	logic [39:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	// level [15:0], phase [18:16], zero padding above
	logic [23:0] m_tdata;
	logic        cfg_we    = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_BITS-1:0]       cfg_data  = '0;

	envelope_scoreboard sb = new();
	logic        steady     = 1'b0;
	int          words_sent = 0;
	int          cycles     = 0;
	logic [31:0] now_ts     = '0;

	linear_adsr_envelope_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(env_word_t'(m_tdata[18:0]));
		m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PERCENT);
	end

	task automatic send_word(logic [1:0] op, logic [31:0] ts);
		while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, ts, op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_input(op, ts);
		words_sent++;
	endtask

	task automatic write_regs(logic [31:0] a, logic [31:0] d, logic [31:0] r,
			logic [15:0] s);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_ATTACK;
		cfg_data  <= a;
		@(posedge clk);
		cfg_index <= CFG_DECAY;
		cfg_data  <= d;
		@(posedge clk);
		cfg_index <= CFG_RELEASE;
		cfg_data  <= r;
		@(posedge clk);
		cfg_index <= CFG_SUSTAIN;
		cfg_data  <= {16'b0, s};
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_lengths(a, d, r, s);
	endtask

	// Steps are scaled to one of the phase lengths so that every phase gets visited.
	function automatic logic [31:0] next_time(logic [31:0] ts);
		logic [31:0] len;
		logic [31:0] span;
		case ($urandom_range(0, 2))
			0:       len = sb.attack_len;
			1:       len = sb.decay_len;
			default: len = sb.release_len;
		endcase
		span = len / 3 + 1;
		case ($urandom_range(0, 19))
			0:       return $urandom;
			1:       return ts - $urandom_range(0, span);
			default: return ts + $urandom_range(0, span);
		endcase
	endfunction

	function automatic logic [1:0] update_op();
		return ($urandom_range(0, 7) == 0) ? OP_SPARE : OP_UPDATE;
	endfunction

	task automatic run_notes(int count);
		int target;
		int k;
		target = words_sent + count;
		while (words_sent < target) begin
			if ($urandom_range(0, 99) < 75) begin
				now_ts = next_time(now_ts);
				send_word(OP_START, now_ts);
				k = $urandom_range(0, 6);
				repeat (k) begin
					now_ts = next_time(now_ts);
					send_word(update_op(), now_ts);
				end
				if ($urandom_range(0, 9) != 0) begin
					now_ts = next_time(now_ts);
					send_word(OP_RELEASE, now_ts);
				end
				k = $urandom_range(0, 5);
				repeat (k) begin
					now_ts = next_time(now_ts);
					send_word(update_op(), now_ts);
				end
			end else begin
				now_ts = next_time(now_ts);
				send_word(2'($urandom_range(0, 3)), now_ts);
			end
		end
	endtask

	initial begin
		int i;
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset lengths: attack 4800, decay 9600, release 24000.
		send_word(OP_UPDATE, 32'd0);
		send_word(OP_RELEASE, 32'd5);
		send_word(OP_SPARE, 32'd7);
		send_word(OP_START, 32'd100);
		send_word(OP_UPDATE, 32'd100);
		send_word(OP_UPDATE, 32'd2500);
		send_word(OP_UPDATE, 32'd4899);
		send_word(OP_UPDATE, 32'd4900);
		// Back into the attack window while in decay: the level holds at full scale.
		send_word(OP_UPDATE, 32'd4000);
		send_word(OP_SPARE, 32'd9000);
		send_word(OP_UPDATE, 32'd14500);
		send_word(OP_UPDATE, 32'd14000);
		send_word(OP_RELEASE, 32'd20000);
		send_word(OP_UPDATE, 32'd32000);
		send_word(OP_RELEASE, 32'd35000);
		send_word(OP_UPDATE, 32'd58999);
		send_word(OP_UPDATE, 32'd59000);
		send_word(OP_UPDATE, 32'd60000);
		send_word(OP_START, 32'hFFFF_F000);
		send_word(OP_UPDATE, 32'h0000_0100);
		send_word(OP_START, 32'h0000_0200);
		send_word(OP_RELEASE, 32'h0000_0300);
		send_word(OP_START, 32'h0000_0400);
		send_word(OP_UPDATE, 32'hFFFF_FFFF);
		send_word(OP_RELEASE, 32'hFFFF_FFFF);
		now_ts = 32'hFFFF_FFFF;

		write_regs(32'd7, 32'd13, 32'd5, 16'h8000);
		run_notes(250);
		write_regs(32'd0, 32'd0, 32'd0, 16'hFFFF);
		run_notes(100);
		write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000);
		run_notes(150);
		write_regs(32'd1, 32'd1, 32'd1, 16'h0001);
		run_notes(100);
		for (i = 0; i < 5; i++) begin
			if (i == 4)
				write_regs($urandom, $urandom, $urandom, 16'($urandom_range(0, 65535)));
			else
				write_regs($urandom_range(0, 3000), $urandom_range(0, 3000),
					$urandom_range(0, 3000), 16'($urandom_range(0, 65535)));
			steady = (i == 1);
			run_notes(150);
		end
		steady = 1'b0;

		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[linear_adsr_envelope_top.f]
+incdir+design
design/lae_pkg.sv
design/lae_div.sv
design/lae_dp.sv
design/lae_ctrl.sv
design/linear_adsr_envelope_top.sv
design/lae_chk.sv
tb/tb_linear_adsr_envelope_top.sv
